@@ hdl/plsm_pkg.sv @@
// ---------------------------------------------------------------------------
// plsm_pkg
// Shared sizes, codes and controller/datapath interface types for the
// Pareto label-set merge unit.
// ---------------------------------------------------------------------------
package plsm_pkg;

   localparam int SETTLED_DEPTH   = 16;
   localparam int PENDING_DEPTH   = 32;
   localparam int CANDIDATE_DEPTH = 16;

   localparam int SET_IDX_W   = $clog2(SETTLED_DEPTH);
   localparam int SET_CNT_W   = $clog2(SETTLED_DEPTH + 1);
   localparam int PEND_IDX_W  = $clog2(PENDING_DEPTH);
   localparam int PEND_CNT_W  = $clog2(PENDING_DEPTH + 1);
   localparam int CAND_IDX_W  = $clog2(CANDIDATE_DEPTH);
   localparam int CAND_CNT_W  = $clog2(CANDIDATE_DEPTH + 1);
   localparam int STORE_CNT_W = (SET_CNT_W > PEND_CNT_W) ? SET_CNT_W : PEND_CNT_W;
   localparam int MERGE_CNT_W = $clog2(PENDING_DEPTH + CANDIDATE_DEPTH + 1);
   localparam int EMIT_CNT_W  = $clog2(SETTLED_DEPTH + PENDING_DEPTH + 1);

   localparam logic [1:0] CMD_LOAD_SETTLED = 2'd0;
   localparam logic [1:0] CMD_LOAD_PENDING = 2'd1;
   localparam logic [1:0] CMD_CANDIDATE    = 2'd2;
   localparam logic [1:0] CMD_CLEAR        = 2'd3;

   localparam logic [1:0] KIND_SETTLED = 2'd0;
   localparam logic [1:0] KIND_PENDING = 2'd1;
   localparam logic [1:0] KIND_EMPTY   = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SET_SKIP,
      ST_SET_CMP,
      ST_SET_TAIL,
      ST_PEND_SKIP,
      ST_PEND_CMP,
      ST_PEND_TAIL,
      ST_MERGE,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_SKIP,
      OP_CMP,
      OP_TAIL,
      OP_MERGE,
      OP_EMIT
   } op_type;

   typedef struct packed {
      logic   accept;
      op_type op;
      logic   sel_pend;
   } dp_cmd_type;

   typedef struct packed {
      logic skip_more;
      logic cmp_more;
      logic cmp_drop;
      logic tail_more;
      logic merge_more;
      logic emit_last;
   } dp_status_type;

endpackage

@@ hdl/plsm_controller.sv @@
// ---------------------------------------------------------------------------
// plsm_controller
// Sequencer: settled sweep, pending sweep, ordered merge, then emission.
// ---------------------------------------------------------------------------
module plsm_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             req_command,
   input  logic                   req_last_candidate,
   input  plsm_pkg::dp_status_type status,
   output plsm_pkg::dp_cmd_type    cmd,
   output logic                   busy
);
   import plsm_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_command == CMD_CANDIDATE && req_last_candidate)
               state_in = ST_SET_SKIP;
         end
         ST_SET_SKIP: begin
            if (!status.skip_more) state_in = ST_SET_CMP;
         end
         ST_SET_CMP: begin
            if (!status.cmp_more)     state_in = ST_SET_TAIL;
            else if (status.cmp_drop) state_in = ST_SET_SKIP;
         end
         ST_SET_TAIL: begin
            if (!status.tail_more) state_in = ST_PEND_SKIP;
         end
         ST_PEND_SKIP: begin
            if (!status.skip_more) state_in = ST_PEND_CMP;
         end
         ST_PEND_CMP: begin
            if (!status.cmp_more)     state_in = ST_PEND_TAIL;
            else if (status.cmp_drop) state_in = ST_PEND_SKIP;
         end
         ST_PEND_TAIL: begin
            if (!status.tail_more) state_in = ST_MERGE;
         end
         ST_MERGE: begin
            if (!status.merge_more) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.emit_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.accept   = accept;
      cmd.op       = OP_NONE;
      cmd.sel_pend = 1'b0;
      unique case (state_ff)
         ST_IDLE:      cmd.op = OP_NONE;
         ST_SET_SKIP:  cmd.op = OP_SKIP;
         ST_SET_CMP:   cmd.op = OP_CMP;
         ST_SET_TAIL:  cmd.op = OP_TAIL;
         ST_PEND_SKIP: begin
            cmd.op = OP_SKIP;
            cmd.sel_pend = 1'b1;
         end
         ST_PEND_CMP: begin
            cmd.op = OP_CMP;
            cmd.sel_pend = 1'b1;
         end
         ST_PEND_TAIL: begin
            cmd.op = OP_TAIL;
            cmd.sel_pend = 1'b1;
         end
         ST_MERGE:     cmd.op = OP_MERGE;
         ST_EMIT:      cmd.op = OP_EMIT;
         default:      cmd.op = OP_NONE;
      endcase
   end

endmodule

@@ hdl/plsm_datapath.sv @@
// ---------------------------------------------------------------------------
// plsm_datapath
// Point stores, sweep/merge pointers, dominance compare and result register.
// ---------------------------------------------------------------------------
module plsm_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  plsm_pkg::dp_cmd_type     cmd,
   input  logic [1:0]              req_command,
   input  logic [31:0]             req_cost_first,
   input  logic [31:0]             req_cost_second,
   output plsm_pkg::dp_status_type  status,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_list_kind,
   output logic [31:0]             rsp_out_first,
   output logic [31:0]             rsp_out_second,
   output logic                    rsp_changed,
   output logic                    rsp_overflow,
   output logic                    rsp_last_result
);
   import plsm_pkg::*;

   logic [63:0] settled_mem [SETTLED_DEPTH];
   logic [63:0] pend0_mem   [PENDING_DEPTH];
   logic [63:0] pend1_mem   [PENDING_DEPTH];
   logic [63:0] cand_mem    [CANDIDATE_DEPTH];

   logic [SET_CNT_W-1:0]   set_cnt_ff,  set_cnt_in;
   logic [PEND_CNT_W-1:0]  pend_cnt_ff, pend_cnt_in;
   logic [CAND_CNT_W-1:0]  cand_cnt_ff, cand_cnt_in;
   logic                   ovf_ff,      ovf_in;
   logic                   bank_ff,     bank_in;
   logic [CAND_CNT_W-1:0]  ci_ff,       ci_in;
   logic [STORE_CNT_W-1:0] sj_ff,       sj_in;
   logic [STORE_CNT_W-1:0] wi_ff,       wi_in;
   logic [MERGE_CNT_W-1:0] mi_ff,       mi_in;
   logic [EMIT_CNT_W-1:0]  ek_ff,       ek_in;
   logic [CANDIDATE_DEPTH-1:0] drop_ff, drop_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff,   kind_in;
   logic [31:0] first_ff,  first_in;
   logic [31:0] second_ff, second_in;
   logic        chg_ff,    chg_in;
   logic        rovf_ff,   rovf_in;
   logic        last_ff,   last_in;

   logic [63:0] in_point, set_rd, pend_rd, cand_rd, store_rd, wr_data;
   logic [SET_IDX_W-1:0]  set_rd_addr, set_wr_addr;
   logic [PEND_IDX_W-1:0] pend_rd_addr, pend_wr_addr;
   logic [EMIT_CNT_W-1:0] emit_pend_idx, total;
   logic [STORE_CNT_W-1:0] store_n;
   logic set_we, pend_we_cur, pend_we_alt, cand_we;
   logic i_ok, j_ok, a_ok, dropped_i;
   logic cf_lt, cf_eq, cs_lt, cs_eq, rel_dom, rel_worse, first_gt, take_pend, merge_over;

   assign in_point = {req_cost_first, req_cost_second};

   // single read port per store
   assign emit_pend_idx = ek_ff - EMIT_CNT_W'(set_cnt_ff);
   assign set_rd_addr   = (cmd.op == OP_EMIT) ? ek_ff[SET_IDX_W-1:0] : sj_ff[SET_IDX_W-1:0];
   assign pend_rd_addr  = (cmd.op == OP_EMIT) ? emit_pend_idx[PEND_IDX_W-1:0]
                                              : sj_ff[PEND_IDX_W-1:0];
   assign set_rd   = settled_mem[set_rd_addr];
   assign pend_rd  = bank_ff ? pend1_mem[pend_rd_addr] : pend0_mem[pend_rd_addr];
   assign cand_rd  = cand_mem[ci_ff[CAND_IDX_W-1:0]];
   assign store_rd = cmd.sel_pend ? pend_rd : set_rd;
   assign store_n  = cmd.sel_pend ? STORE_CNT_W'(pend_cnt_ff) : STORE_CNT_W'(set_cnt_ff);

   assign i_ok      = ci_ff < cand_cnt_ff;
   assign j_ok      = sj_ff < store_n;
   assign a_ok      = sj_ff < STORE_CNT_W'(pend_cnt_ff);
   assign dropped_i = drop_ff[ci_ff[CAND_IDX_W-1:0]];

   // candidate against stored point
   assign cf_lt     = cand_rd[63:32] < store_rd[63:32];
   assign cf_eq     = cand_rd[63:32] == store_rd[63:32];
   assign cs_lt     = cand_rd[31:0] < store_rd[31:0];
   assign cs_eq     = cand_rd[31:0] == store_rd[31:0];
   assign rel_dom   = ((cf_lt || cf_eq) && cs_lt) || (cf_lt && (cs_lt || cs_eq));
   assign rel_worse = !rel_dom && !cf_lt && !cs_lt;
   assign first_gt  = !cf_lt && !cf_eq;

   // ties keep the older pending entry first
   assign take_pend  = !i_ok || (a_ok && !(cand_rd < pend_rd));
   assign merge_over = mi_ff > MERGE_CNT_W'(PENDING_DEPTH);
   assign total      = EMIT_CNT_W'(set_cnt_ff) + EMIT_CNT_W'(pend_cnt_ff);

   assign status.skip_more  = i_ok && dropped_i;
   assign status.cmp_more   = i_ok && j_ok;
   assign status.cmp_drop   = rel_worse;
   assign status.tail_more  = j_ok;
   assign status.merge_more = a_ok || i_ok;
   assign status.emit_last  = (total == '0) || (EMIT_CNT_W'(ek_ff + 1'b1) == total);

   always_comb begin
      set_cnt_in  = set_cnt_ff;
      pend_cnt_in = pend_cnt_ff;
      cand_cnt_in = cand_cnt_ff;
      ovf_in      = ovf_ff;
      bank_in     = bank_ff;
      ci_in       = ci_ff;
      sj_in       = sj_ff;
      wi_in       = wi_ff;
      mi_in       = mi_ff;
      ek_in       = ek_ff;
      drop_in     = drop_ff;
      set_we      = 1'b0;
      pend_we_cur = 1'b0;
      pend_we_alt = 1'b0;
      cand_we     = 1'b0;
      set_wr_addr  = wi_ff[SET_IDX_W-1:0];
      pend_wr_addr = wi_ff[PEND_IDX_W-1:0];
      wr_data      = store_rd;
      rsp_valid_in = 1'b0;
      kind_in      = KIND_SETTLED;
      first_in     = 32'd0;
      second_in    = 32'd0;
      chg_in       = pend_cnt_ff != '0;
      rovf_in      = ovf_ff;
      last_in      = status.emit_last;

      if (cmd.accept) begin
         ci_in   = '0;
         sj_in   = '0;
         wi_in   = '0;
         mi_in   = '0;
         ek_in   = '0;
         drop_in = '0;
         wr_data = in_point;
         case (req_command)
            CMD_LOAD_SETTLED: begin
               set_wr_addr = set_cnt_ff[SET_IDX_W-1:0];
               if (set_cnt_ff < SET_CNT_W'(SETTLED_DEPTH)) begin
                  set_we     = 1'b1;
                  set_cnt_in = set_cnt_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
            end
            CMD_LOAD_PENDING: begin
               pend_wr_addr = pend_cnt_ff[PEND_IDX_W-1:0];
               if (pend_cnt_ff < PEND_CNT_W'(PENDING_DEPTH)) begin
                  pend_we_cur = 1'b1;
                  pend_cnt_in = pend_cnt_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
            end
            CMD_CANDIDATE: begin
               if (cand_cnt_ff < CAND_CNT_W'(CANDIDATE_DEPTH)) begin
                  cand_we     = 1'b1;
                  cand_cnt_in = cand_cnt_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
            end
            default: begin
               set_cnt_in  = '0;
               pend_cnt_in = '0;
               cand_cnt_in = '0;
               ovf_in      = 1'b0;
            end
         endcase
      end

      case (cmd.op)
         OP_SKIP: begin
            if (status.skip_more) ci_in = ci_ff + 1'b1;
         end
         OP_CMP: begin
            if (status.cmp_more) begin
               if (rel_dom) begin
                  sj_in = sj_ff + 1'b1;
               end else if (rel_worse) begin
                  drop_in[ci_ff[CAND_IDX_W-1:0]] = 1'b1;
                  ci_in = ci_ff + 1'b1;
               end else if (first_gt) begin
                  set_we      = !cmd.sel_pend;
                  pend_we_cur = cmd.sel_pend;
                  wi_in = wi_ff + 1'b1;
                  sj_in = sj_ff + 1'b1;
               end else begin
                  ci_in = ci_ff + 1'b1;
               end
            end
         end
         OP_TAIL: begin
            if (j_ok) begin
               set_we      = !cmd.sel_pend;
               pend_we_cur = cmd.sel_pend;
               wi_in = wi_ff + 1'b1;
               sj_in = sj_ff + 1'b1;
            end else begin
               if (cmd.sel_pend) pend_cnt_in = wi_ff[PEND_CNT_W-1:0];
               else              set_cnt_in  = wi_ff[SET_CNT_W-1:0];
               ci_in = '0;
               sj_in = '0;
               wi_in = '0;
               mi_in = '0;
            end
         end
         OP_MERGE: begin
            pend_wr_addr = mi_ff[PEND_IDX_W-1:0];
            wr_data      = take_pend ? pend_rd : cand_rd;
            if (status.merge_more) begin
               if (i_ok && dropped_i) begin
                  ci_in = ci_ff + 1'b1;
               end else begin
                  pend_we_alt = mi_ff < MERGE_CNT_W'(PENDING_DEPTH);
                  mi_in = mi_ff + 1'b1;
                  if (take_pend) sj_in = sj_ff + 1'b1;
                  else           ci_in = ci_ff + 1'b1;
               end
            end else begin
               // excess past the pending depth is lost
               pend_cnt_in = merge_over ? PEND_CNT_W'(PENDING_DEPTH)
                                        : mi_ff[PEND_CNT_W-1:0];
               if (merge_over) ovf_in = 1'b1;
               bank_in     = !bank_ff;
               cand_cnt_in = '0;
               ek_in       = '0;
            end
         end
         OP_EMIT: begin
            rsp_valid_in = 1'b1;
            ek_in = ek_ff + 1'b1;
            if (total == '0) begin
               kind_in = KIND_EMPTY;
               chg_in  = 1'b0;
            end else if (ek_ff < EMIT_CNT_W'(set_cnt_ff)) begin
               kind_in   = KIND_SETTLED;
               first_in  = set_rd[63:32];
               second_in = set_rd[31:0];
            end else begin
               kind_in   = KIND_PENDING;
               first_in  = pend_rd[63:32];
               second_in = pend_rd[31:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (set_we) settled_mem[set_wr_addr] <= wr_data;
      if (cand_we) cand_mem[cand_cnt_ff[CAND_IDX_W-1:0]] <= in_point;
      if ((pend_we_cur && !bank_ff) || (pend_we_alt && bank_ff))
         pend0_mem[pend_wr_addr] <= wr_data;
      if ((pend_we_cur && bank_ff) || (pend_we_alt && !bank_ff))
         pend1_mem[pend_wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_cnt_ff   <= '0;
         pend_cnt_ff  <= '0;
         cand_cnt_ff  <= '0;
         ovf_ff       <= 1'b0;
         bank_ff      <= 1'b0;
         ci_ff        <= '0;
         sj_ff        <= '0;
         wi_ff        <= '0;
         mi_ff        <= '0;
         ek_ff        <= '0;
         drop_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         set_cnt_ff   <= set_cnt_in;
         pend_cnt_ff  <= pend_cnt_in;
         cand_cnt_ff  <= cand_cnt_in;
         ovf_ff       <= ovf_in;
         bank_ff      <= bank_in;
         ci_ff        <= ci_in;
         sj_ff        <= sj_in;
         wi_ff        <= wi_in;
         mi_ff        <= mi_in;
         ek_ff        <= ek_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      first_ff  <= first_in;
      second_ff <= second_in;
      chg_ff    <= chg_in;
      rovf_ff   <= rovf_in;
      last_ff   <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_list_kind   = kind_ff;
   assign rsp_out_first   = first_ff;
   assign rsp_out_second  = second_ff;
   assign rsp_changed     = chg_ff;
   assign rsp_overflow    = rovf_ff;
   assign rsp_last_result = last_ff;

endmodule

@@ hdl/pareto_label_set_merge_unit.sv @@
// ---------------------------------------------------------------------------
// pareto_label_set_merge_unit
// Settled/pending Pareto sets of two-cost points with batch dominance merge.
// ---------------------------------------------------------------------------
// Usage:
//  Commands are taken when start is high and busy low. Settled, pending and
//  candidate loads and clears give no result.
//  A candidate with req_last_candidate set starts a merge run: a sweep of the
//  candidates over the settled set, one over the pending set, then the ordered
//  merge into the pending set. Steps of a sweep or the merge go one at a
//  time, paced by the single-ported point stores.
//  Results then follow one per cycle, settled survivors first and then the
//  pending set, each registered and shown for one cycle with rsp_valid
//  in the cycle after it is read; rsp_last_result marks the final one.
//  With both sets empty a single empty marker is sent. busy falls with
//  the last result, so the next command may be taken while it is still
//  on the ports. The receiver cannot stall the result channel.
//  Reset empties all stores and clears the overflow flag; the point memories
//  themselves are not cleared.
// ---------------------------------------------------------------------------
module pareto_label_set_merge_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_cost_first,
   input  logic [31:0] req_cost_second,
   input  logic        req_last_candidate,
   output logic        rsp_valid,
   output logic [1:0]  rsp_list_kind,
   output logic [31:0] rsp_out_first,
   output logic [31:0] rsp_out_second,
   output logic        rsp_changed,
   output logic        rsp_overflow,
   output logic        rsp_last_result
);
   import plsm_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   plsm_controller u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .req_command        (req_command),
      .req_last_candidate (req_last_candidate),
      .status             (status),
      .cmd                (cmd),
      .busy               (busy)
   );

   plsm_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_command     (req_command),
      .req_cost_first  (req_cost_first),
      .req_cost_second (req_cost_second),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_list_kind   (rsp_list_kind),
      .rsp_out_first   (rsp_out_first),
      .rsp_out_second  (rsp_out_second),
      .rsp_changed     (rsp_changed),
      .rsp_overflow    (rsp_overflow),
      .rsp_last_result (rsp_last_result)
   );

`ifndef SYNTHESIS
   // a run always ends with its final result transfer
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_valid && rsp_last_result)
      else $error("run ended without final result");

   // results of one run come back to back
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |=> rsp_valid)
      else $error("gap inside result burst");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_list_kind == KIND_EMPTY |-> rsp_last_result && !rsp_changed)
      else $error("empty marker malformed");
`endif

endmodule

@@ test/pareto_label_set_merge_unit_test.sv @@
// ---------------------------------------------------------------------------
// pareto_label_set_merge_unit_test
// Self-checking bench for the Pareto label-set merge unit. Commands are driven
// through the start/busy handshake. A behavioural copy of the settled, pending
// and candidate stores predicts every merge run. Each strobed result is
// compared field by field against a queue of predicted points.
// ---------------------------------------------------------------------------
module pareto_label_set_merge_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import plsm_pkg::*;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] first;
      logic [31:0] second;
      logic        changed;
      logic        overflow;
      logic        last;
   } point_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_command = CMD_CLEAR;
   logic [31:0] req_cost_first = '0;
   logic [31:0] req_cost_second = '0;
   logic        req_last_candidate = 1'b0;
   logic        rsp_valid;
   logic [1:0]  rsp_list_kind;
   logic [31:0] rsp_out_first;
   logic [31:0] rsp_out_second;
   logic        rsp_changed;
   logic        rsp_overflow;
   logic        rsp_last_result;

   pareto_label_set_merge_unit uut (.*);

   always #6 clock = ~clock;

   // behavioural copy of the block's stores
   logic [63:0] settled_pts [SETTLED_DEPTH];
   logic [63:0] pending_pts [PENDING_DEPTH];
   logic [63:0] cand_pts [CANDIDATE_DEPTH];
   bit          cand_gone [CANDIDATE_DEPTH];
   int          settled_n, pending_n, cand_n;
   bit          overflow_flag;

   point_result_type expected_points [$];
   int  error_count;
   int  send_gap_pct;
   int  items_sent;
   longint cycle_count;

   task automatic report_mismatch(input string what);
      $display("mismatch @%0t: %s", $realtime, what);
      error_count++;
   endtask

   // 1: candidate dominates stored, 2: candidate dominated or equal, 0: neither
   function automatic int dominance(input logic [63:0] c, input logic [63:0] s);
      logic [31:0] cf, cs, sf, ss;
      cf = c[63:32]; cs = c[31:0]; sf = s[63:32]; ss = s[31:0];
      if ((cf <= sf && cs < ss) || (cf < sf && cs <= ss)) return 1;
      if (cf >= sf && cs >= ss) return 2;
      return 0;
   endfunction

   task automatic sweep_store(input bit use_pending);
      int i, j, w, n, r;
      logic [63:0] s;
      i = 0; j = 0; w = 0;
      n = use_pending ? pending_n : settled_n;
      while (i < cand_n && cand_gone[i]) i++;
      while (i < cand_n && j < n) begin
         s = use_pending ? pending_pts[j] : settled_pts[j];
         r = dominance(cand_pts[i], s);
         if (r == 1) begin
            j++;
         end else if (r == 2) begin
            cand_gone[i] = 1'b1;
            i++;
            while (i < cand_n && cand_gone[i]) i++;
         end else if (cand_pts[i][63:32] > s[63:32]) begin
            if (use_pending) pending_pts[w] = s; else settled_pts[w] = s;
            w++; j++;
         end else begin
            i++;
         end
      end
      while (j < n) begin
         if (use_pending) pending_pts[w] = pending_pts[j];
         else settled_pts[w] = settled_pts[j];
         w++; j++;
      end
      if (use_pending) pending_n = w; else settled_n = w;
   endtask

   task automatic add_expected(input logic [1:0] kind, input logic [63:0] p,
                               input bit chg, input bit last);
      point_result_type e;
      e.kind = kind; e.first = p[63:32]; e.second = p[31:0];
      e.changed = chg; e.overflow = overflow_flag; e.last = last;
      expected_points.insert(expected_points.size(), e);
   endtask

   task automatic predict_merge();
      logic [63:0] merged [PENDING_DEPTH + CANDIDATE_DEPTH];
      int a, b, m, total, k;
      bit chg;
      a = 0; b = 0; m = 0; k = 0;
      foreach (cand_gone[x]) cand_gone[x] = 1'b0;
      sweep_store(1'b0);
      sweep_store(1'b1);
      while (a < pending_n || b < cand_n) begin
         if (b < cand_n && cand_gone[b]) begin
            b++;
         end else if (b >= cand_n || (a < pending_n && !(cand_pts[b] < pending_pts[a]))) begin
            merged[m] = pending_pts[a];
            m++; a++;
         end else begin
            merged[m] = cand_pts[b];
            m++; b++;
         end
      end
      if (m > PENDING_DEPTH) begin
         m = PENDING_DEPTH;
         overflow_flag = 1'b1;
      end
      for (int i = 0; i < m; i++) pending_pts[i] = merged[i];
      pending_n = m;
      cand_n = 0;
      chg = pending_n > 0;
      total = settled_n + pending_n;
      if (total == 0) begin
         add_expected(KIND_EMPTY, 64'd0, 1'b0, 1'b1);
      end else begin
         for (int i = 0; i < settled_n; i++, k++)
            add_expected(KIND_SETTLED, settled_pts[i], chg, k + 1 == total);
         for (int i = 0; i < pending_n; i++, k++)
            add_expected(KIND_PENDING, pending_pts[i], chg, k + 1 == total);
      end
   endtask

   task automatic predict_command(input logic [1:0] cmd, input logic [63:0] p,
                                  input bit last);
      case (cmd)
         CMD_LOAD_SETTLED: begin
            if (settled_n < SETTLED_DEPTH) begin
               settled_pts[settled_n] = p;
               settled_n++;
            end else overflow_flag = 1'b1;
         end
         CMD_LOAD_PENDING: begin
            if (pending_n < PENDING_DEPTH) begin
               pending_pts[pending_n] = p;
               pending_n++;
            end else overflow_flag = 1'b1;
         end
         CMD_CANDIDATE: begin
            if (cand_n < CANDIDATE_DEPTH) begin
               cand_pts[cand_n] = p;
               cand_n++;
            end else overflow_flag = 1'b1;
            if (last) predict_merge();
         end
         default: begin
            settled_n = 0; pending_n = 0; cand_n = 0; overflow_flag = 1'b0;
         end
      endcase
   endtask

   // one command transfer; start stays high only across back-to-back sends
   task automatic send_command(input logic [1:0] cmd, input logic [31:0] f,
                               input logic [31:0] s, input bit last);
      while ($urandom_range(99) < send_gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_command <= cmd;
      req_cost_first <= f;
      req_cost_second <= s;
      req_last_candidate <= last;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      predict_command(cmd, {f, s}, last);
   endtask

   task automatic go_quiet();
      start <= 1'b0;
      @(posedge clock);
      while (expected_points.size() != 0) @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      point_result_type e;
      if (!reset && rsp_valid) begin
         if (expected_points.size() == 0) begin
            report_mismatch("unexpected result");
         end else begin
            e = expected_points[0];
            expected_points.delete(0);
            if (rsp_list_kind !== e.kind)
               report_mismatch($sformatf("list_kind %0d want %0d", rsp_list_kind, e.kind));
            if (rsp_out_first !== e.first)
               report_mismatch($sformatf("out_first %h want %h", rsp_out_first, e.first));
            if (rsp_out_second !== e.second)
               report_mismatch($sformatf("out_second %h want %h", rsp_out_second, e.second));
            if (rsp_changed !== e.changed)
               report_mismatch($sformatf("changed %b want %b", rsp_changed, e.changed));
            if (rsp_overflow !== e.overflow)
               report_mismatch($sformatf("overflow %b want %b", rsp_overflow, e.overflow));
            if (rsp_last_result !== e.last)
               report_mismatch($sformatf("last_result %b want %b", rsp_last_result, e.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 400000) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic test_directed();
      send_gap_pct = 0;
      // clear with a stray last flag, then a merge into empty sets
      send_command(CMD_CANDIDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_command(CMD_CANDIDATE, 32'd0, 32'hFFFF_FFFF, 1'b0);
      send_command(CMD_CLEAR, 32'd0, 32'd0, 1'b1);
      send_command(CMD_CANDIDATE, 32'd5, 32'd5, 1'b1);
      // candidate equal, dominating, incomparable; stray last flags on loads
      send_command(CMD_LOAD_SETTLED, 32'd0, 32'hFFFF_FFFF, 1'b1);
      send_command(CMD_LOAD_SETTLED, 32'd10, 32'd10, 1'b0);
      send_command(CMD_LOAD_PENDING, 32'd20, 32'd3, 1'b1);
      send_command(CMD_CANDIDATE, 32'd4, 32'd4, 1'b0);
      send_command(CMD_CANDIDATE, 32'd20, 32'd3, 1'b0);
      send_command(CMD_CANDIDATE, 32'hFFFF_FFFF, 32'd0, 1'b1);
      // unsorted batch
      send_command(CMD_CANDIDATE, 32'd30, 32'd1, 1'b0);
      send_command(CMD_CANDIDATE, 32'd2, 32'd2, 1'b1);
      go_quiet();
      // overflow of every store, sticky until clear
      for (int i = 0; i < 17; i++) send_command(CMD_LOAD_SETTLED, i, 100 - i, 1'b0);
      for (int i = 0; i < 33; i++) send_command(CMD_LOAD_PENDING, 200 + i, 50 - i, 1'b0);
      for (int i = 0; i < 17; i++) send_command(CMD_CANDIDATE, 300 + i, i, i == 16);
      send_command(CMD_CLEAR, 32'd0, 32'd0, 1'b0);
      // merge overflow on the pending set
      for (int i = 0; i < 30; i++) send_command(CMD_LOAD_PENDING, 2 * i, 1000 - 2 * i, 1'b0);
      for (int i = 0; i < 6; i++) send_command(CMD_CANDIDATE, 2 * i + 1, 999 - 2 * i, i == 5);
      send_command(CMD_CLEAR, 32'd0, 32'd0, 1'b0);
      go_quiet();
   endtask

   task automatic random_batch();
      int ns, np, nc;
      logic [31:0] f, s;
      logic [31:0] span;
      span = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : 32'd60;
      if ($urandom_range(3) == 0)
         send_command(CMD_CLEAR, $urandom, $urandom, 1'($urandom_range(1)));
      ns = $urandom_range(3); np = $urandom_range(4); nc = $urandom_range(1, 4);
      f = 0;
      for (int i = 0; i < ns; i++) begin
         f = f + $urandom_range(span / 8);
         send_command(CMD_LOAD_SETTLED, f, $urandom_range(span), 1'($urandom_range(1)));
      end
      f = 0;
      for (int i = 0; i < np; i++) begin
         f = f + $urandom_range(span / 8);
         send_command(CMD_LOAD_PENDING, f, $urandom_range(span), 1'($urandom_range(1)));
      end
      f = 0;
      for (int i = 0; i < nc; i++) begin
         if ($urandom_range(9) == 0) f = $urandom; else f = f + $urandom_range(span / 8);
         s = $urandom_range(span);
         send_command(CMD_CANDIDATE, f, s, i == nc - 1);
      end
   endtask

   task automatic test_random(input int gap_pct, input int items_goal);
      int start_items;
      send_gap_pct = gap_pct;
      start_items = items_sent;
      while (items_sent - start_items < items_goal) begin
         random_batch();
      end
   endtask

   initial begin
      error_count = 0;
      cycle_count = 0;
      items_sent = 0;
      settled_n = 0; pending_n = 0; cand_n = 0; overflow_flag = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(0, 22);
      test_random(56, 22);
      go_quiet();
      test_random(13, 22);
      test_random(0, 22);
      go_quiet();
      repeat (60) @(posedge clock);
      if (error_count == 0 && expected_points.size() == 0) begin
         $display("simulation ok");
      end else begin
         if (expected_points.size() != 0) report_mismatch("results still outstanding");
         $display("simulation failed");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
hdl/plsm_pkg.sv
hdl/plsm_controller.sv
hdl/plsm_datapath.sv
hdl/pareto_label_set_merge_unit.sv
test/pareto_label_set_merge_unit_test.sv
